// ----- rtl/mrcs_pkg.sv -----
`default_nettype none

package mrcs_pkg;

  // Field widths of the external interface.
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned TOTAL_W = 18;
  localparam int unsigned SUM_W   = 13;
  localparam int unsigned IDX_W   = 5;
  localparam int unsigned CNT_W   = 6;

  // Default storage depth and count register reset value.
  localparam int unsigned MAX_DIM_DEFAULT = 32;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(32);

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

  // One element as handed from the front stage to the column stage.
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               first_row;
    logic               last_row;
    logic               first_col;
    logic               last_elem;
    logic [TOTAL_W-1:0] total;
    logic [IDX_W-1:0]   best_row_idx;
    logic [SUM_W-1:0]   best_row_sum;
  } item_t;

  // A count of zero acts as one, and a count beyond the storage acts as its depth.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] cnt,
                                                 input int unsigned max_dim);
    logic [CNT_W-1:0] res;
    res = cnt;
    if (cnt == '0) begin
      res = CNT_W'(1);
    end else if (32'(cnt) > max_dim) begin
      res = CNT_W'(max_dim);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mrcs_ram.sv -----
`default_nettype none

module mrcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [ADDR_W-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [ADDR_W-1:0]        raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/mrcs_front.sv -----
`default_nettype none

module mrcs_front #(
  parameter int unsigned MAX_DIM = mrcs_pkg::MAX_DIM_DEFAULT,
  parameter int unsigned POS_W   = 5
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [mrcs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mrcs_pkg::CNT_W-1:0]         cfg_data_i,
  input  wire logic                               accept_i,
  input  wire logic [mrcs_pkg::VALUE_W-1:0]       value_i,
  output mrcs_pkg::item_t                         item_o,
  output logic      [POS_W-1:0]                   col_o
);

  localparam int unsigned CNT_W = mrcs_pkg::CNT_W;
  localparam int unsigned CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int unsigned EXT_W = POS_W + mrcs_pkg::IDX_W;

  logic [CNT_W-1:0] row_cnt_q, row_cnt_d;
  logic [CNT_W-1:0] col_cnt_q, col_cnt_d;
  logic [POS_W-1:0] row_pos_q, row_pos_d;
  logic [POS_W-1:0] col_pos_q, col_pos_d;

  logic [mrcs_pkg::SUM_W-1:0]   row_acc_q, row_acc_d;
  logic [mrcs_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [mrcs_pkg::SUM_W-1:0]   best_sum_q, best_sum_d;
  logic [mrcs_pkg::IDX_W-1:0]   best_idx_q, best_idx_d;

  logic [CNT_W-1:0] rows, cols;
  logic             out_of_range;
  logic [POS_W-1:0] r, c;
  logic             first_row, first_col, last_row, last_col;
  logic [EXT_W-1:0] r_wide;

  always_comb begin
    rows = mrcs_pkg::eff_count(row_cnt_q, MAX_DIM);
    cols = mrcs_pkg::eff_count(col_cnt_q, MAX_DIM);

    // After the counts shrink the position may lie outside the matrix.
    out_of_range = (CMP_W'(row_pos_q) >= CMP_W'(rows)) ||
                   (CMP_W'(col_pos_q) >= CMP_W'(cols));
    r = out_of_range ? '0 : row_pos_q;
    c = out_of_range ? '0 : col_pos_q;

    first_row = (r == '0);
    first_col = (c == '0);
    last_row  = (CMP_W'(r) == CMP_W'(rows - CNT_W'(1)));
    last_col  = (CMP_W'(c) == CMP_W'(cols - CNT_W'(1)));
    r_wide    = EXT_W'(r);

    row_acc_d = first_col ? mrcs_pkg::SUM_W'(value_i)
                          : row_acc_q + mrcs_pkg::SUM_W'(value_i);
    total_d   = (first_row && first_col) ? mrcs_pkg::TOTAL_W'(value_i)
                                         : total_q + mrcs_pkg::TOTAL_W'(value_i);

    best_sum_d = best_sum_q;
    best_idx_d = best_idx_q;
    if (last_col && (first_row || (row_acc_d > best_sum_q))) begin
      best_sum_d = row_acc_d;
      best_idx_d = r_wide[mrcs_pkg::IDX_W-1:0];
    end

    col_pos_d = last_col ? '0 : c + POS_W'(1);
    row_pos_d = r;
    if (last_col) begin
      row_pos_d = last_row ? '0 : r + POS_W'(1);
    end

    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        mrcs_pkg::CFG_ROW_COUNT:    row_cnt_d = cfg_data_i;
        mrcs_pkg::CFG_COLUMN_COUNT: col_cnt_d = cfg_data_i;
        default: ;
      endcase
    end

    item_o.value        = value_i;
    item_o.first_row    = first_row;
    item_o.last_row     = last_row;
    item_o.first_col    = first_col;
    item_o.last_elem    = last_row && last_col;
    item_o.total        = total_d;
    item_o.best_row_idx = best_idx_d;
    item_o.best_row_sum = best_sum_d;
    col_o               = c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= mrcs_pkg::COUNT_RESET;
      col_cnt_q <= mrcs_pkg::COUNT_RESET;
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (cfg_we_i) begin
      // Any register write starts a new matrix.
      row_cnt_q <= row_cnt_d;
      col_cnt_q <= col_cnt_d;
      row_pos_q <= '0;
      col_pos_q <= '0;
    end else if (accept_i) begin
      row_pos_q <= row_pos_d;
      col_pos_q <= col_pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      row_acc_q  <= row_acc_d;
      total_q    <= total_d;
      best_sum_q <= best_sum_d;
      best_idx_q <= best_idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mrcs_col.sv -----
`default_nettype none

module mrcs_col #(
  parameter int unsigned POS_W = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              accept_i,
  input  wire mrcs_pkg::item_t                   item_i,
  input  wire logic [POS_W-1:0]                  col_i,
  output logic                                   ready_o,
  input  wire logic [mrcs_pkg::SUM_W-1:0]        rdata_i,
  output logic                                   we_o,
  output logic      [POS_W-1:0]                  waddr_o,
  output logic      [mrcs_pkg::SUM_W-1:0]        wdata_o,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic      [mrcs_pkg::TOTAL_W-1:0]      grand_total_o,
  output logic      [mrcs_pkg::IDX_W-1:0]        best_row_index_o,
  output logic      [mrcs_pkg::SUM_W-1:0]        best_row_sum_o,
  output logic      [mrcs_pkg::IDX_W-1:0]        best_column_index_o,
  output logic      [mrcs_pkg::SUM_W-1:0]        best_column_sum_o
);

  localparam int unsigned SUM_W = mrcs_pkg::SUM_W;
  localparam int unsigned IDX_W = mrcs_pkg::IDX_W;
  localparam int unsigned EXT_W = POS_W + IDX_W;

  logic            s1_valid_q;
  mrcs_pkg::item_t s1_item_q;
  logic [POS_W-1:0] s1_col_q;

  logic             fwd_valid_q;
  logic [POS_W-1:0] fwd_col_q;
  logic [SUM_W-1:0] fwd_sum_q;

  logic [SUM_W-1:0] best_sum_q, best_sum_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;

  logic                         out_valid_q;
  logic [mrcs_pkg::TOTAL_W-1:0] out_total_q;
  logic [IDX_W-1:0]             out_row_idx_q;
  logic [SUM_W-1:0]             out_row_sum_q;
  logic [IDX_W-1:0]             out_col_idx_q;
  logic [SUM_W-1:0]             out_col_sum_q;

  logic             out_free, s1_fire;
  logic [SUM_W-1:0] base, csum;
  logic [EXT_W-1:0] c_wide;

  always_comb begin
    out_free = !out_valid_q || out_ready_i;
    s1_fire  = s1_valid_q && (!s1_item_q.last_elem || out_free);
    ready_o  = !s1_valid_q || s1_fire;

    // The write from the previous element has not reached the read port yet.
    base = (fwd_valid_q && (fwd_col_q == s1_col_q)) ? fwd_sum_q : rdata_i;
    csum = s1_item_q.first_row ? SUM_W'(s1_item_q.value)
                               : base + SUM_W'(s1_item_q.value);
    c_wide = EXT_W'(s1_col_q);

    best_sum_d = best_sum_q;
    best_idx_d = best_idx_q;
    if (s1_item_q.last_row && (s1_item_q.first_col || (csum > best_sum_q))) begin
      best_sum_d = csum;
      best_idx_d = c_wide[IDX_W-1:0];
    end

    we_o    = s1_fire;
    waddr_o = s1_col_q;
    wdata_o = csum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept_i) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      // Hold the bypass while the stage waits on the output.
      if (!s1_valid_q || s1_fire) begin
        fwd_valid_q <= s1_fire;
      end
      if (s1_fire && s1_item_q.last_elem) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_item_q <= item_i;
      s1_col_q  <= col_i;
    end
    if (s1_fire) begin
      fwd_col_q  <= s1_col_q;
      fwd_sum_q  <= csum;
      best_sum_q <= best_sum_d;
      best_idx_q <= best_idx_d;
    end
    if (s1_fire && s1_item_q.last_elem) begin
      out_total_q   <= s1_item_q.total;
      out_row_idx_q <= s1_item_q.best_row_idx;
      out_row_sum_q <= s1_item_q.best_row_sum;
      out_col_idx_q <= best_idx_d;
      out_col_sum_q <= best_sum_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign grand_total_o       = out_total_q;
  assign best_row_index_o    = out_row_idx_q;
  assign best_row_sum_o      = out_row_sum_q;
  assign best_column_index_o = out_col_idx_q;
  assign best_column_sum_o   = out_col_sum_q;

endmodule

`default_nettype wire

// ----- rtl/matrix_row_column_sum_max.sv -----
// Streams a matrix in row-major order, one element per transfer, and after the
// final element returns one result: the grand total, the row and the column
// with the largest sum (the earliest one wins a tie) and those two sums. The
// block takes one element per clock cycle, except while a final element waits
// for a pending result to be taken; the rate is set by the column-sum memory,
// which is read when an element is taken and written back from the column
// stage register, with a bypass register covering a one-column matrix where
// the same entry is read while it is being written. The result is held in an
// output register, so the next matrix keeps streaming while it waits. A
// write to either count register restarts the matrix; counts of zero act as
// one and counts above MAX_DIM act as MAX_DIM. Only write the counts while no
// result is pending. No clearing pass is needed after reset: the first row of
// every matrix overwrites the column sums.

`default_nettype none

module matrix_row_column_sum_max #(
  parameter int unsigned MAX_DIM = mrcs_pkg::MAX_DIM_DEFAULT
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,

  input  wire logic                               cfg_we_i,
  input  wire logic [mrcs_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [mrcs_pkg::CNT_W-1:0]         cfg_data_i,

  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [mrcs_pkg::VALUE_W-1:0]       element_value_i,

  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic      [mrcs_pkg::TOTAL_W-1:0]       grand_total_o,
  output logic      [mrcs_pkg::IDX_W-1:0]         best_row_index_o,
  output logic      [mrcs_pkg::SUM_W-1:0]         best_row_sum_o,
  output logic      [mrcs_pkg::IDX_W-1:0]         best_column_index_o,
  output logic      [mrcs_pkg::SUM_W-1:0]         best_column_sum_o
);

  // Width of a row or column position, and of a column-memory address.
  localparam int unsigned POS_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

  logic                       accept;
  mrcs_pkg::item_t            item;
  logic [POS_W-1:0]           col;
  logic                       ram_we;
  logic [POS_W-1:0]           ram_waddr;
  logic [mrcs_pkg::SUM_W-1:0] ram_wdata;
  logic [mrcs_pkg::SUM_W-1:0] ram_rdata;

  // An element transfer happens when the column stage can take it.
  assign accept = in_valid_i && in_ready_o;

  // Front stage: positions, row sum, total and best row, all in registers.
  mrcs_front #(
    .MAX_DIM (MAX_DIM),
    .POS_W   (POS_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .value_i     (element_value_i),
    .item_o      (item),
    .col_o       (col)
  );

  // Column sums live in memory; the read is launched with the transfer.
  mrcs_ram #(
    .WIDTH (mrcs_pkg::SUM_W),
    .DEPTH (MAX_DIM)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (col),
    .rdata_o (ram_rdata)
  );

  // Column stage: add, write back, track the best column and hold the result.
  mrcs_col #(
    .POS_W (POS_W)
  ) u_col (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .accept_i            (accept),
    .item_i              (item),
    .col_i               (col),
    .ready_o             (in_ready_o),
    .rdata_i             (ram_rdata),
    .we_o                (ram_we),
    .waddr_o             (ram_waddr),
    .wdata_o             (ram_wdata),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .grand_total_o       (grand_total_o),
    .best_row_index_o    (best_row_index_o),
    .best_row_sum_o      (best_row_sum_o),
    .best_column_index_o (best_column_index_o),
    .best_column_sum_o   (best_column_sum_o)
  );

endmodule

`default_nettype wire
